// File: hdl/rrss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared widths, codes and controller/datapath link types of the scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 8;
	localparam int TIME_W      = 16;
	localparam int STATUS_W    = 3;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RAN      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd4;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic REG_SLICE   = 1'b0;
	localparam logic REG_HORIZON = 1'b1;

	localparam logic [TIME_W-1:0] SLICE_RESET   = 16'd4;
	localparam logic [TIME_W-1:0] HORIZON_RESET = 16'd100;

	typedef struct packed {
		logic load;
		logic arrive;
		logic choose;
		logic drop;
		logic run;
		logic emit;
	} rrss_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic drop_now;
		logic out_free;
	} rrss_stat_t;
endpackage
`default_nettype wire

// File: hdl/rrss_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_req_if / rrss_rsp_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface rrss_req_if;
	import rrss_pkg::*;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [ID_W-1:0]   task_id;
	logic [TIME_W-1:0] burst_length;
	modport source (output valid, operation, task_id, burst_length, input ready);
	modport sink   (input valid, operation, task_id, burst_length, output ready);
endinterface

interface rrss_rsp_if;
	import rrss_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     ran_id;
	logic [TIME_W-1:0]   first_run_time;
	logic [TIME_W-1:0]   finish_tick;
	logic [TIME_W-1:0]   now_tick;
	modport source (output valid, status, ran_id, first_run_time, finish_tick, now_tick,
		input ready);
	modport sink   (input valid, status, ran_id, first_run_time, finish_tick, now_tick,
		output ready);
endinterface
`default_nettype wire

// File: hdl/rrss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_ctrl
// Sequencer: load, execute, then for a tick the drop loop and run, then emit.
// ----------------------------------------------------------------------------
module rrss_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire rrss_pkg::rrss_stat_t stat,
	output rrss_pkg::rrss_cmd_t      cmd
);
	import rrss_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DROP = 3'd2;
	localparam logic [2:0] S_RUN  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_tick) begin
					cmd.choose = 1'b1;
					state_d    = S_DROP;
				end else begin
					cmd.arrive = 1'b1;
					state_d    = S_EMIT;
				end
			end
			S_DROP: begin
				// hold here while unstarted entries are met past the horizon
				if (stat.drop_now) cmd.drop = 1'b1;
				else state_d = S_RUN;
			end
			S_RUN: begin
				cmd.run = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// File: hdl/rrss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_datapath
// Ready queue, scheduling registers, configuration and result registers.
// ----------------------------------------------------------------------------
module rrss_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rrss_pkg::rrss_cmd_t            cmd,
	output rrss_pkg::rrss_stat_t                stat,
	input  wire logic                           in_operation,
	input  wire logic [rrss_pkg::ID_W-1:0]      in_task_id,
	input  wire logic [rrss_pkg::TIME_W-1:0]    in_burst_length,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [rrss_pkg::STATUS_W-1:0]       out_status,
	output logic [rrss_pkg::ID_W-1:0]           out_ran_id,
	output logic [rrss_pkg::TIME_W-1:0]         out_first_run_time,
	output logic [rrss_pkg::TIME_W-1:0]         out_finish_tick,
	output logic [rrss_pkg::TIME_W-1:0]         out_now_tick,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rrss_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rrss_pkg::DATA_W-1:0]    pwdata,
	output logic [rrss_pkg::DATA_W-1:0]         prdata
);
	import rrss_pkg::*;

	// queue entries
	logic [ID_W-1:0]   ids_q     [QUEUE_DEPTH];
	logic [TIME_W-1:0] bursts_q  [QUEUE_DEPTH];
	logic [TIME_W-1:0] served_q  [QUEUE_DEPTH];
	logic [TIME_W-1:0] start_q   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] started_q;

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  cur_q;
	logic              cv_q;
	logic [TIME_W-1:0] su_q;
	logic [TIME_W-1:0] tick_q;
	logic [TIME_W-1:0] slice_q;
	logic [TIME_W-1:0] horizon_q;

	// captured request
	logic              op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] burst_q;
	logic [TIME_W-1:0] now_q;
	logic              past_q;

	// pending result
	logic [STATUS_W-1:0] res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic [TIME_W-1:0]   res_first_q;
	logic [TIME_W-1:0]   res_finish_q;

	logic [CNT_W-1:0]  cur_ext;
	logic [CNT_W-1:0]  cur_next;
	logic [CNT_W-1:0]  cnt_less;
	logic [IDX_W-1:0]  last_idx;
	logic [TIME_W-1:0] served_inc;
	logic              finishing;
	logic              do_remove;
	logic              cfg_wr;

	assign cur_ext    = {1'b0, cur_q};
	assign cur_next   = cur_ext + CNT_W'(1);
	assign cnt_less   = count_q - CNT_W'(1);
	assign last_idx   = cnt_less[IDX_W-1:0];
	assign served_inc = (served_q[cur_q] == TIME_MAX) ? TIME_MAX
		: served_q[cur_q] + TIME_W'(1);
	assign finishing  = cv_q && (served_inc >= bursts_q[cur_q]);
	assign do_remove  = cmd.drop || (cmd.run && finishing);

	assign stat.is_tick  = (op_q == OP_TICK);
	assign stat.drop_now = past_q && cv_q && !started_q[cur_q];
	assign stat.out_free = !out_valid || out_ready;

	// configuration port
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HORIZON) ? {16'd0, horizon_q} : {16'd0, slice_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q   <= SLICE_RESET;
			horizon_q <= HORIZON_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_HORIZON) horizon_q <= pwdata[TIME_W-1:0];
			else slice_q <= pwdata[TIME_W-1:0];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_operation;
			id_q    <= in_task_id;
			burst_q <= in_burst_length;
			now_q   <= tick_q;
			past_q  <= (tick_q >= horizon_q);
		end
	end

	// entry payload: append at tail, shift down on removal, update on run
	always_ff @(posedge clk) begin
		if (cmd.arrive && !past_q && (count_q < CNT_W'(QUEUE_DEPTH))) begin
			ids_q[count_q[IDX_W-1:0]]    <= id_q;
			bursts_q[count_q[IDX_W-1:0]] <= burst_q;
			served_q[count_q[IDX_W-1:0]] <= '0;
			start_q[count_q[IDX_W-1:0]]  <= '0;
		end
		if (cmd.run && cv_q && !finishing) begin
			served_q[cur_q] <= served_inc;
			if (!started_q[cur_q]) start_q[cur_q] <= now_q;
		end
		if (do_remove) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				if (IDX_W'(i) >= cur_q) begin
					ids_q[i]    <= ids_q[i+1];
					bursts_q[i] <= bursts_q[i+1];
					served_q[i] <= served_q[i+1];
					start_q[i]  <= start_q[i+1];
				end
			end
		end
	end

	// started flags and scheduling state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
			count_q   <= '0;
			cur_q     <= '0;
			cv_q      <= 1'b0;
			su_q      <= '0;
			tick_q    <= '0;
		end else begin
			if (cmd.arrive && !past_q && (count_q < CNT_W'(QUEUE_DEPTH))) begin
				started_q[count_q[IDX_W-1:0]] <= 1'b0;
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.choose) begin
				if (!cv_q) begin
					su_q  <= '0;
					cur_q <= '0;
					cv_q  <= (count_q != '0);
				end else if (su_q >= slice_q) begin
					su_q  <= '0;
					cur_q <= (cur_next >= count_q) ? '0 : cur_next[IDX_W-1:0];
					cv_q  <= (count_q != '0);
				end else if (count_q == '0) begin
					cv_q <= 1'b0;
				end else if (cur_ext >= count_q) begin
					cur_q <= '0;
				end
			end
			if (cmd.drop) begin
				su_q <= '0;
				if (cur_ext >= cnt_less) cur_q <= '0;
				cv_q <= (cnt_less != '0);
			end
			if (cmd.run) begin
				if (cv_q) begin
					if (finishing) begin
						su_q <= '0;
						if (cur_ext >= cnt_less) begin
							cur_q <= '0;
							cv_q  <= 1'b0;
						end
					end else begin
						su_q <= (su_q == TIME_MAX) ? TIME_MAX : su_q + TIME_W'(1);
						started_q[cur_q] <= 1'b1;
					end
				end
				if (tick_q != TIME_MAX) tick_q <= tick_q + TIME_W'(1);
			end
			if (do_remove) begin
				for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
					if (IDX_W'(i) >= cur_q) started_q[i] <= started_q[i+1];
				end
				started_q[last_idx] <= 1'b0;
				count_q <= cnt_less;
			end
		end
	end

	// result formation
	always_ff @(posedge clk) begin
		if (cmd.arrive) begin
			res_id_q     <= id_q;
			res_first_q  <= '0;
			res_finish_q <= '0;
			res_status_q <= (past_q || (count_q >= CNT_W'(QUEUE_DEPTH))) ? ST_REFUSED
				: ST_ACCEPTED;
		end
		if (cmd.run) begin
			if (!cv_q) begin
				res_status_q <= ST_IDLE;
				res_id_q     <= '0;
				res_first_q  <= '0;
				res_finish_q <= '0;
			end else if (finishing) begin
				res_status_q <= ST_FINISHED;
				res_id_q     <= ids_q[cur_q];
				res_first_q  <= started_q[cur_q] ? start_q[cur_q] : now_q;
				res_finish_q <= now_q;
			end else begin
				res_status_q <= ST_RAN;
				res_id_q     <= ids_q[cur_q];
				res_first_q  <= '0;
				res_finish_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status         <= res_status_q;
			out_ran_id         <= res_id_q;
			out_first_run_time <= res_first_q;
			out_finish_tick    <= res_finish_q;
			out_now_tick       <= now_q;
		end
	end
endmodule
`default_nettype wire

// File: hdl/round_robin_slice_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// An arrival passes the execute and emit states; a tick passes execute, the drop
// loop over unstarted entries past the horizon (up to 16), run and emit. Emit
// waits until the output register is free. One transaction at a time: a new
// request is taken only once the sequencer is back in idle.
// Reset (arst_n low) empties the queue, zeroes tick count and slice usage, and
// restores slice length 4 and admission horizon 100.
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Round-robin time-slice scheduler over an ordered ready queue of 16 tasks.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	rrss_req_if.sink                         req,
	rrss_rsp_if.source                       rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rrss_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rrss_pkg::DATA_W-1:0] pwdata,
	output logic [rrss_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import rrss_pkg::*;

	rrss_cmd_t  cmd;
	rrss_stat_t stat;

	// writes always complete in the access cycle
	assign pready = 1'b1;

	// sequencer: take a transaction, execute, for a tick the drop loop and run, then emit
	rrss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// queue, timing state, configuration and the result register
	rrss_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.in_operation       (req.operation),
		.in_task_id         (req.task_id),
		.in_burst_length    (req.burst_length),
		.out_valid          (rsp.valid),
		.out_ready          (rsp.ready),
		.out_status         (rsp.status),
		.out_ran_id         (rsp.ran_id),
		.out_first_run_time (rsp.first_run_time),
		.out_finish_tick    (rsp.finish_tick),
		.out_now_tick       (rsp.now_tick),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata)
	);
endmodule
`default_nettype wire

// File: test/tb_round_robin_slice_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_slice_scheduler
// Drives arrivals and ticks into the scheduler with random idling on both
// channels, predicts each result with an independent queue model and checks
// every result transaction field by field, across several register settings.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [2:0]  status;
	logic [7:0]  ran_id;
	logic [15:0] first_run;
	logic [15:0] finish;
	logic [15:0] now;
} sched_result_t;

class sched_scoreboard;
	logic [7:0]  q_id[16];
	logic [15:0] q_burst[16];
	logic [15:0] q_served[16];
	logic [15:0] q_start[16];
	bit          q_started[16];
	int          q_len;
	int          cur;
	bit          cur_ok;
	logic [15:0] used;
	logic [15:0] ticks;
	logic [15:0] slice_len;
	logic [15:0] horizon;
	sched_result_t pending[$];
	int          errors;

	function new();
		q_len = 0; cur = 0; cur_ok = 0; used = 0; ticks = 0;
		slice_len = 16'd4; horizon = 16'd100; errors = 0;
		foreach (q_started[i]) q_started[i] = 0;
	endfunction

	function void drop_slot(int s);
		for (int i = s; i + 1 < q_len; i++) begin
			q_id[i] = q_id[i+1]; q_burst[i] = q_burst[i+1];
			q_served[i] = q_served[i+1]; q_start[i] = q_start[i+1];
			q_started[i] = q_started[i+1];
		end
		q_len--;
		q_started[q_len] = 0;
	endfunction

	// note an accepted input transaction and queue its expected result
	function void note_request(logic op, logic [7:0] id, logic [15:0] burst);
		sched_result_t r;
		bit past;
		past = ticks >= horizon;
		r.status = rrss_pkg::ST_ACCEPTED; r.ran_id = 0; r.first_run = 0; r.finish = 0;
		r.now = ticks;
		if (op == rrss_pkg::OP_ARRIVE) begin
			r.ran_id = id;
			if (q_len >= 16 || past) r.status = rrss_pkg::ST_REFUSED;
			else begin
				q_id[q_len] = id; q_burst[q_len] = burst; q_served[q_len] = 0;
				q_start[q_len] = 0; q_started[q_len] = 0; q_len++;
			end
			pending.push_back(r);
			return;
		end
		if (!cur_ok) begin
			used = 0; cur = 0; cur_ok = q_len > 0;
		end else if (used >= slice_len) begin
			used = 0; cur++;
			if (cur >= q_len) cur = 0;
			cur_ok = q_len > 0;
		end
		if (cur_ok && cur >= q_len) cur = 0;
		if (q_len == 0) cur_ok = 0;
		while (past && cur_ok && !q_started[cur]) begin
			drop_slot(cur);
			used = 0;
			if (cur >= q_len) cur = 0;
			cur_ok = q_len > 0;
		end
		if (!cur_ok) r.status = rrss_pkg::ST_IDLE;
		else begin
			r.ran_id = q_id[cur];
			if (used != 16'hFFFF) used++;
			if (!q_started[cur]) begin
				q_started[cur] = 1; q_start[cur] = ticks;
			end
			if (q_served[cur] != 16'hFFFF) q_served[cur]++;
			if (q_served[cur] >= q_burst[cur]) begin
				r.status = rrss_pkg::ST_FINISHED; r.first_run = q_start[cur]; r.finish = ticks;
				drop_slot(cur);
				used = 0;
				if (cur >= q_len) begin
					cur = 0; cur_ok = 0;
				end
			end else r.status = rrss_pkg::ST_RAN;
		end
		if (ticks != 16'hFFFF) ticks++;
		pending.push_back(r);
	endfunction

	function void check_result(sched_result_t got);
		sched_result_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result status=%0d id=%0d", $time, got.status, got.ran_id);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got !== exp_r) begin
			$display("%0t: mismatch expected st=%0d id=%0d first=%0d fin=%0d now=%0d",
				$time, exp_r.status, exp_r.ran_id, exp_r.first_run, exp_r.finish, exp_r.now);
			$display("%0t:          actual   st=%0d id=%0d first=%0d fin=%0d now=%0d",
				$time, got.status, got.ran_id, got.first_run, got.finish, got.now);
			errors++;
		end
	endfunction
endclass

module tb_round_robin_slice_scheduler;
	import rrss_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	rrss_req_if req ();
	rrss_rsp_if rsp ();

	round_robin_slice_scheduler u_top (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sched_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	longint cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// give up well beyond the slowest correct run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver: stall at random, sample result transactions at the rising edge
	initial begin
		sched_result_t got;
		rsp.ready = 0;
		forever begin
			@(negedge clk);
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				got.status = rsp.status; got.ran_id = rsp.ran_id;
				got.first_run = rsp.first_run_time; got.finish = rsp.finish_tick;
				got.now = rsp.now_tick;
				sb.check_result(got);
			end
		end
	end

	// one request transaction: hold valid until accepted, idle beforehand at random
	task automatic send_item(logic op, logic [7:0] id, logic [15:0] burst);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		req.valid <= 1; req.operation <= op; req.task_id <= id; req.burst_length <= burst;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, id, burst);
		@(negedge clk);
		req.valid <= 0;
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= {16'($urandom()), val};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		if (idx == REG_SLICE) sb.slice_len = val; else sb.horizon = val;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// wait for every outstanding result, then let a drop loop run out
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic random_phase(int count, int max_burst);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 45)
				send_item(OP_ARRIVE, 8'($urandom()), 16'($urandom_range(max_burst)));
			else
				send_item(OP_TICK, 8'($urandom()), 16'($urandom()));
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0; recv_idle_pct = 0;
		arst_n = 0;
		req.valid = 0; req.operation = OP_ARRIVE; req.task_id = 0; req.burst_length = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes of id and burst, zero burst, full queue, expiry
		send_item(OP_TICK, 8'h00, 16'h0000);
		send_item(OP_ARRIVE, 8'hFF, 16'hFFFF);
		send_item(OP_ARRIVE, 8'h00, 16'h0000);
		send_item(OP_ARRIVE, 8'hA5, 16'h0001);
		for (int i = 0; i < 14; i++) send_item(OP_ARRIVE, 8'(i + 1), 16'(2));
		repeat (7) send_item(OP_TICK, 8'hFF, 16'hFFFF);
		drain();

		// horizon reached: refuse arrivals, drop unstarted entries
		write_reg(REG_HORIZON, 16'd0);
		write_reg(REG_SLICE, 16'd1);
		send_item(OP_ARRIVE, 8'h11, 16'd3);
		repeat (6) send_item(OP_TICK, 8'h00, 16'h0);
		drain();

		// random phases through several settings
		write_reg(REG_HORIZON, 16'hFFFF);
		write_reg(REG_SLICE, 16'd0);
		send_idle_pct = 25; recv_idle_pct = 52;
		random_phase(350, 6);
		drain();
		write_reg(REG_SLICE, 16'd3);
		send_idle_pct = 52; recv_idle_pct = 25;
		random_phase(350, 12);
		// hold off until every expected result has come
		drain();
		write_reg(REG_SLICE, 16'hFFFF);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(250, 10);
		drain();
		write_reg(REG_SLICE, 16'd2);
		write_reg(REG_HORIZON, sb.ticks + 16'd150);
		random_phase(600, 8);
		drain();
		write_reg(REG_HORIZON, 16'hFFFF);
		write_reg(REG_SLICE, 16'd4);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// File: sim.f
hdl/rrss_pkg.sv
hdl/rrss_if.sv
hdl/rrss_ctrl.sv
hdl/rrss_datapath.sv
hdl/round_robin_slice_scheduler.sv
test/tb_round_robin_slice_scheduler.sv
